### rtl/crs_pkg.sv
// ----------------------------------------------------------------------------
// crs_pkg
// shared constants and status codes of the chinese remainder solver
// ----------------------------------------------------------------------------
package crs_pkg;

  localparam int MAX_MODULI_DEF  = 8;
  localparam int VALUE_WIDTH_DEF = 31;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NOT_COPRIME = 2'd1,
    ST_OVERFLOW    = 2'd2,
    ST_BAD_INPUT   = 2'd3
  } status_t;

endpackage

### rtl/crs_divider.sv
// ----------------------------------------------------------------------------
// crs_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module crs_divider #(
  parameter int W = crs_pkg::VALUE_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);
  import crs_pkg::*;

  localparam int CW = $clog2(W);

  logic          run;
  logic [CW-1:0] cnt;
  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [W-1:0]  dsr;
  logic [W:0]    trial;
  logic [W:0]    diff;

  assign trial = {rem, quo[W-1]};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !run) begin
        rem <= '0;
        quo <= dividend;
        dsr <= divisor;
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        if (trial >= {1'b0, dsr}) begin
          rem <= diff[W-1:0];
          quo <= {quo[W-2:0], 1'b1};
        end else begin
          rem <= trial[W-1:0];
          quo <= {quo[W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CW'(W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

### rtl/crs_mulmod.sv
// ----------------------------------------------------------------------------
// crs_mulmod
// shift and add modular multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module crs_mulmod #(
  parameter int W = crs_pkg::VALUE_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W:0]   a,
  input  logic [W-1:0] b,
  input  logic [W:0]   m,
  output logic         done,
  output logic [W:0]   result
);
  import crs_pkg::*;

  logic         run;
  logic [W:0]   acc;
  logic [W:0]   aa;
  logic [W-1:0] bb;
  logic [W:0]   mm;
  logic [W+1:0] sum;
  logic [W+1:0] dbl;

  assign sum = {1'b0, acc} + {1'b0, aa};
  assign dbl = {aa, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !run) begin
        acc <= '0;
        aa  <= a;
        bb  <= b;
        mm  <= m;
        run <= 1'b1;
      end else if (run) begin
        if (bb == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          if (bb[0]) begin
            acc <= (sum >= {1'b0, mm}) ? (W+1)'(sum - {1'b0, mm}) : sum[W:0];
          end
          aa <= (dbl >= {1'b0, mm}) ? (W+1)'(dbl - {1'b0, mm}) : dbl[W:0];
          bb <= bb >> 1;
        end
      end
    end
  end

  assign result = acc;

endmodule

### rtl/chinese_remainder_solver.sv
// ----------------------------------------------------------------------------
// chinese_remainder_solver
// solves a set of congruences x == residue (mod modulus)
// ----------------------------------------------------------------------------
// Congruence words are taken one per cycle while busy is low (start high
// loads a word). Each pair is stored; the word with last_item set starts the
// solve and busy stays high until the result is out. A solve costs one
// division and one shift-add multiply per modulus for the product, then per
// modulus a cofactor division, a reduction division, the extended Euclid loop
// (one division and one modular multiply per step) and three more
// multiply or divide runs. Divisions run in the shared restoring divider
// and modular multiplies in the shift-add unit. The result is shown
// on solution and status for exactly one cycle with valid high; there is no
// backpressure, so the receiver must take it then. Status reports bad input
// (zero modulus or too many pairs) first, then product overflow, then moduli
// that are not coprime; solution is zero on any error.
// ----------------------------------------------------------------------------
module chinese_remainder_solver #(
  parameter int MAX_MODULI  = crs_pkg::MAX_MODULI_DEF,
  parameter int VALUE_WIDTH = crs_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [VALUE_WIDTH-1:0] residue,
  input  logic [VALUE_WIDTH-1:0] modulus,
  input  logic                   last_item,
  output logic                   valid,
  output logic [VALUE_WIDTH-1:0] solution,
  output logic [1:0]             status
);
  import crs_pkg::*;

  localparam int W     = VALUE_WIDTH;
  localparam int CNT_W = $clog2(MAX_MODULI + 1);
  localparam int IDX_W = (MAX_MODULI > 1) ? $clog2(MAX_MODULI) : 1;

  typedef enum logic [4:0] {
    S_IDLE, S_BEGIN, S_PROD_RD, S_OVF_GO, S_OVF_W, S_PROD_W,
    S_SUM_RD, S_COF_GO, S_COF_W, S_R1_W, S_EU_TEST, S_EU_DIV_W,
    S_EU_MUL_W, S_AMOD_W, S_C_W, S_TERM_W, S_FINISH
  } state_t;

  state_t           state;
  status_t          stat;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] idx;
  logic             bad;
  logic [W-1:0]     s;
  logic [W-1:0]     acc;
  logic [W-1:0]     m_r;
  logic [W-1:0]     r0, r1, t0, t1;
  logic [W-1:0]     rd_n, rd_a;

  // pair storage, registered read at the current index
  logic [W-1:0] res_mem [MAX_MODULI];
  logic [W-1:0] mod_mem [MAX_MODULI];

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (accept && (count < CNT_W'(MAX_MODULI))) begin
      res_mem[count[IDX_W-1:0]] <= residue;
      mod_mem[count[IDX_W-1:0]] <= modulus;
    end
    rd_n <= mod_mem[idx[IDX_W-1:0]];
    rd_a <= res_mem[idx[IDX_W-1:0]];
  end

  // shared units and their operand select
  logic         div_start, div_done;
  logic [W-1:0] div_dvd, div_dsr, div_q, div_r;
  logic         mm_start, mm_done;
  logic [W:0]   mm_a, mm_m, mm_res;
  logic [W-1:0] mm_b;

  crs_divider #(.W(W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dvd),
    .divisor(div_dsr), .done(div_done), .quotient(div_q), .remainder(div_r)
  );

  crs_mulmod #(.W(W)) u_mul (
    .clk(clk), .rst(rst), .start(mm_start), .a(mm_a), .b(mm_b), .m(mm_m),
    .done(mm_done), .result(mm_res)
  );

  // euclid quotient reduced mod n (it never exceeds n)
  logic [W-1:0] q_mod;
  assign q_mod = (div_q >= rd_n) ? (div_q - rd_n) : div_q;

  // cofactor reduced mod the product (equal only for a modulus of one)
  logic [W-1:0] m_mod;
  assign m_mod = (m_r == s) ? '0 : m_r;

  logic [W:0] acc_sum;
  assign acc_sum = {1'b0, acc} + {1'b0, mm_res[W-1:0]};

  logic last_idx;
  assign last_idx = ((idx + 1'b1) == count);

  always_comb begin
    div_start = 1'b0;
    div_dvd   = r0;
    div_dsr   = r1;
    mm_start  = 1'b0;
    mm_a      = {1'b0, t0};
    mm_b      = t1;
    mm_m      = {1'b0, rd_n};
    unique case (state)
      S_OVF_GO: begin
        div_start = 1'b1;
        div_dvd   = {W{1'b1}};
        div_dsr   = rd_n;
      end
      S_OVF_W: begin
        mm_start = div_done && (s <= div_q);
        mm_a     = {1'b0, s};
        mm_b     = rd_n;
        mm_m     = {1'b1, {W{1'b0}}};
      end
      S_COF_GO: begin
        div_start = 1'b1;
        div_dvd   = s;
        div_dsr   = rd_n;
      end
      S_COF_W: begin
        div_start = div_done;
        div_dvd   = div_q;
        div_dsr   = rd_n;
      end
      S_EU_TEST: begin
        div_start = 1'b1;
        if (r1 != '0) begin
          div_dvd = r0;
          div_dsr = r1;
        end else begin
          div_start = (r0 == W'(1));
          div_dvd   = rd_a;
          div_dsr   = rd_n;
        end
      end
      S_EU_DIV_W: begin
        mm_start = div_done;
        mm_a     = {1'b0, q_mod};
        mm_b     = t1;
      end
      S_AMOD_W: begin
        mm_start = div_done;
        mm_a     = {1'b0, t0};
        mm_b     = div_r;
      end
      S_C_W: begin
        mm_start = mm_done;
        mm_a     = {1'b0, m_mod};
        mm_b     = mm_res[W-1:0];
        mm_m     = {1'b0, s};
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      bad   <= 1'b0;
      idx   <= '0;
      valid <= 1'b0;
    end else begin
      valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (count >= CNT_W'(MAX_MODULI)) begin
              bad <= 1'b1;
            end else begin
              if (modulus == '0) bad <= 1'b1;
              count <= count + 1'b1;
            end
            if (last_item) state <= S_BEGIN;
          end
        end
        S_BEGIN: begin
          idx <= '0;
          s   <= W'(1);
          acc <= '0;
          if (bad) begin
            stat  <= ST_BAD_INPUT;
            state <= S_FINISH;
          end else begin
            state <= S_PROD_RD;
          end
        end
        S_PROD_RD: state <= S_OVF_GO;
        S_OVF_GO:  state <= S_OVF_W;
        S_OVF_W: begin
          if (div_done) begin
            if (s > div_q) begin
              stat  <= ST_OVERFLOW;
              state <= S_FINISH;
            end else begin
              state <= S_PROD_W;
            end
          end
        end
        S_PROD_W: begin
          if (mm_done) begin
            s <= mm_res[W-1:0];
            if (last_idx) begin
              idx   <= '0;
              state <= S_SUM_RD;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_PROD_RD;
            end
          end
        end
        S_SUM_RD: state <= S_COF_GO;
        S_COF_GO: state <= S_COF_W;
        S_COF_W: begin
          if (div_done) begin
            m_r   <= div_q;
            state <= S_R1_W;
          end
        end
        S_R1_W: begin
          if (div_done) begin
            r0    <= rd_n;
            r1    <= div_r;
            t0    <= '0;
            t1    <= {{(W-1){1'b0}}, (rd_n != W'(1))};
            state <= S_EU_TEST;
          end
        end
        S_EU_TEST: begin
          if (r1 != '0) begin
            state <= S_EU_DIV_W;
          end else if (r0 == W'(1)) begin
            state <= S_AMOD_W;
          end else begin
            stat  <= ST_NOT_COPRIME;
            state <= S_FINISH;
          end
        end
        S_EU_DIV_W: begin
          if (div_done) begin
            r0    <= r1;
            r1    <= div_r;
            state <= S_EU_MUL_W;
          end
        end
        S_EU_MUL_W: begin
          if (mm_done) begin
            t0 <= t1;
            t1 <= (t0 >= mm_res[W-1:0]) ? (t0 - mm_res[W-1:0])
                                        : (t0 + (rd_n - mm_res[W-1:0]));
            state <= S_EU_TEST;
          end
        end
        S_AMOD_W: if (div_done) state <= S_C_W;
        S_C_W:    if (mm_done) state <= S_TERM_W;
        S_TERM_W: begin
          if (mm_done) begin
            acc <= (acc_sum >= {1'b0, s}) ? W'(acc_sum - {1'b0, s}) : acc_sum[W-1:0];
            if (last_idx) begin
              stat  <= ST_OK;
              state <= S_FINISH;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_SUM_RD;
            end
          end
        end
        S_FINISH: begin
          valid    <= 1'b1;
          solution <= (stat == ST_OK) ? acc : '0;
          status   <= stat;
          count    <= '0;
          bad      <= 1'b0;
          idx      <= '0;
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result word only leaves from the finish step
  a_valid_src: assert property (@(posedge clk) disable iff (rst)
    valid |-> $past(state == S_FINISH))
    else $error("result word without finish step");

  // block is free again when the result word is shown
  a_valid_idle: assert property (@(posedge clk) disable iff (rst)
    valid |-> !busy)
    else $error("busy while result word shown");

  // stored pair count never passes the store depth
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_MODULI))
    else $error("pair count overflow");

  // bezout coefficients stay reduced mod n
  a_t_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_EU_TEST) |-> ((t0 < rd_n) && (t1 < rd_n)))
    else $error("euclid coefficient out of range");

endmodule
